// File: rtl/core/edf_two_task_scheduler_defines.svh
// ----------------------------------------------------------------------------
// edf_two_task_scheduler_defines
// Assertion macros shared by the scheduler checker.
// ----------------------------------------------------------------------------
`ifndef EDF_TWO_TASK_SCHEDULER_DEFINES_SVH
`define EDF_TWO_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define EDF2_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("edf2 check failed");

// next-cycle implication, off while reset is high
`define EDF2_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("edf2 check failed");

// next-cycle implication, always on
`define EDF2_ASSERT_NXT_ALL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("edf2 check failed");

`endif

// File: rtl/core/edf2_pkg.sv
// ----------------------------------------------------------------------------
// edf2_pkg
// Types, constants and helpers of the two-task EDF scheduler.
// ----------------------------------------------------------------------------
package edf2_pkg;

   localparam int TICK_W     = 32;
   localparam int WORK_W     = 16;
   localparam int MISS_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      TASK_IDLE = 2'd0,
      TASK_A    = 2'd1,
      TASK_B    = 2'd2
   } task_id_type;

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_A   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPUTE_A  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADLINE_A = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_B   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPUTE_B  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADLINE_B = 3'd5;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] period;
      logic [WORK_W-1:0]     compute;
      logic [CSR_DATA_W-1:0] deadline;
   } task_cfg_type;

   localparam task_cfg_type CFG_RESET_A = '{period: 16'd200, compute: 16'd100,
                                            deadline: 16'd200};
   localparam task_cfg_type CFG_RESET_B = '{period: 16'd500, compute: 16'd250,
                                            deadline: 16'd500};

   typedef struct packed {
      logic              ready;
      logic [TICK_W-1:0] due;
      logic              done;
      logic              missed;
      logic [MISS_W-1:0] misses;
   } task_status_type;

   typedef struct packed {
      task_id_type       running_task;
      logic              switched;
      logic              done_a;
      logic              done_b;
      logic              missed_a;
      logic              missed_b;
      logic [MISS_W-1:0] misses_a;
      logic [MISS_W-1:0] misses_b;
      logic [TICK_W-1:0] now_tick;
   } rsp_payload_type;

   function automatic logic [TICK_W-1:0] sat_add(input logic [TICK_W-1:0] a,
                                                 input logic [CSR_DATA_W-1:0] b);
      logic [TICK_W:0] sum;
      sum = {1'b0, a} + {{(TICK_W+1-CSR_DATA_W){1'b0}}, b};
      return sum[TICK_W] ? {TICK_W{1'b1}} : sum[TICK_W-1:0];
   endfunction

endpackage

// File: rtl/core/edf2_if.sv
// ----------------------------------------------------------------------------
// edf2_if
// Valid/ready channels of the scheduler: tick request and result.
// ----------------------------------------------------------------------------
interface edf2_req_if;
   logic valid;
   logic ready;
   logic advance;

   modport source (output valid, output advance, input ready);
   modport sink   (input valid, input advance, output ready);
endinterface

interface edf2_rsp_if import edf2_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        running_task;
   logic              switched;
   logic              done_a;
   logic              done_b;
   logic              missed_a;
   logic              missed_b;
   logic [MISS_W-1:0] misses_a;
   logic [MISS_W-1:0] misses_b;
   logic [TICK_W-1:0] now_tick;

   modport source (output valid, output running_task, output switched,
                   output done_a, output done_b, output missed_a, output missed_b,
                   output misses_a, output misses_b, output now_tick, input ready);
   modport sink   (input valid, input running_task, input switched,
                   input done_a, input done_b, input missed_a, input missed_b,
                   input misses_a, input misses_b, input now_tick, output ready);
endinterface

// File: rtl/core/edf2_task.sv
// ----------------------------------------------------------------------------
// edf2_task
// One task slot: work left, deadline, next arrival, active flag, miss count.
// ----------------------------------------------------------------------------
module edf2_task import edf2_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              charge,
   input  logic [TICK_W-1:0] tick_new,
   input  logic [TICK_W-1:0] due_init,
   input  task_cfg_type      cfg,
   output task_status_type   status
);

   logic [WORK_W-1:0] work_ff, work_in, work_dec;
   logic [TICK_W-1:0] due_ff, due_in;
   logic [TICK_W-1:0] arr_ff, arr_in;
   logic              active_ff, active_in;
   logic [MISS_W-1:0] miss_ff, miss_in;
   logic              done, missed, act_kept, act_live, arrive;

   always_comb begin
      work_dec = (charge && work_ff != '0) ? work_ff - 1'b1 : work_ff;
      done     = charge && (work_dec == '0);
      act_kept = active_ff && !done;
      missed   = act_kept && (tick_new > due_ff);
      act_live = act_kept && !missed;
      miss_in  = (missed && miss_ff != '1) ? miss_ff + 1'b1 : miss_ff;
      arrive   = (tick_new >= arr_ff) && ((work_dec == '0) || !act_live);

      work_in   = arrive ? cfg.compute : work_dec;
      active_in = arrive || act_live;
      due_in    = arrive ? sat_add(tick_new, cfg.deadline) : due_ff;
      arr_in    = arrive ? sat_add(tick_new, cfg.period) : arr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff   <= '0;
         due_ff    <= due_init;
         arr_ff    <= '0;
         active_ff <= 1'b0;
         miss_ff   <= '0;
      end else if (step) begin
         work_ff   <= work_in;
         due_ff    <= due_in;
         arr_ff    <= arr_in;
         active_ff <= active_in;
         miss_ff   <= miss_in;
      end
   end

   assign status.ready  = active_in && (work_in != '0);
   assign status.due    = due_in;
   assign status.done   = step && done;
   assign status.missed = step && missed;
   assign status.misses = step ? miss_in : miss_ff;

endmodule

// File: rtl/core/edf_two_task_scheduler.sv
// ----------------------------------------------------------------------------
// edf_two_task_scheduler
// Two-task earliest-deadline-first tick scheduler with deadline-miss counts.
// ----------------------------------------------------------------------------
// Each request transaction is one tick (advance=1) or a status poll (advance=0)
// and yields exactly one response transaction. A new request is taken every
// clock cycle unless a held request waits behind an untaken response. A request
// passes the request register, then the response register; the whole tick update
// of both task slots and the deadline compare is combinational between them.
// The response register lets the next request enter while a response waits to
// be taken. There is no clearing pass after reset. Task settings written over the
// csr port take effect at the task's next arrival; indexes 6 and 7 are ignored.
module edf_two_task_scheduler import edf2_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   edf2_req_if.sink              req_chan,
   edf2_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   task_cfg_type      cfg_ff [2];
   logic              in_valid_ff;
   logic              in_adv_ff;
   logic              out_valid_ff;
   rsp_payload_type   out_ff, out_in;
   logic [TICK_W-1:0] tick_ff, tick_new;
   task_id_type       cur_ff, chosen;
   logic              out_room, s1_move, step;
   task_status_type   stat_a, stat_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[0] <= CFG_RESET_A;
         cfg_ff[1] <= CFG_RESET_B;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PERIOD_A:   cfg_ff[0].period   <= csr_wdata;
            CSR_COMPUTE_A:  cfg_ff[0].compute  <= csr_wdata;
            CSR_DEADLINE_A: cfg_ff[0].deadline <= csr_wdata;
            CSR_PERIOD_B:   cfg_ff[1].period   <= csr_wdata;
            CSR_COMPUTE_B:  cfg_ff[1].compute  <= csr_wdata;
            CSR_DEADLINE_B: cfg_ff[1].deadline <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_room       = !out_valid_ff || rsp_chan.ready;
   assign s1_move        = in_valid_ff && out_room;
   assign req_chan.ready = !in_valid_ff || out_room;
   assign step           = s1_move && in_adv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_adv_ff <= req_chan.advance;
      end
   end

   assign tick_new = (tick_ff == '1) ? tick_ff : tick_ff + 1'b1;

   edf2_task u_task_a (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .charge   (cur_ff == TASK_A),
      .tick_new (tick_new),
      .due_init ({{(TICK_W-CSR_DATA_W){1'b0}}, CFG_RESET_A.deadline}),
      .cfg      (cfg_ff[0]),
      .status   (stat_a)
   );

   edf2_task u_task_b (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .charge   (cur_ff == TASK_B),
      .tick_new (tick_new),
      .due_init ({{(TICK_W-CSR_DATA_W){1'b0}}, CFG_RESET_B.deadline}),
      .cfg      (cfg_ff[1]),
      .status   (stat_b)
   );

   always_comb begin
      if (stat_b.ready && (!stat_a.ready || stat_b.due < stat_a.due)) begin
         chosen = TASK_B;
      end else if (stat_a.ready) begin
         chosen = TASK_A;
      end else begin
         chosen = TASK_IDLE;
      end

      out_in.running_task = in_adv_ff ? chosen : cur_ff;
      out_in.switched     = in_adv_ff && (chosen != cur_ff);
      out_in.done_a       = stat_a.done;
      out_in.done_b       = stat_b.done;
      out_in.missed_a     = stat_a.missed;
      out_in.missed_b     = stat_b.missed;
      out_in.misses_a     = stat_a.misses;
      out_in.misses_b     = stat_b.misses;
      out_in.now_tick     = in_adv_ff ? tick_new : tick_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         cur_ff  <= TASK_IDLE;
      end else if (step) begin
         tick_ff <= tick_new;
         cur_ff  <= chosen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_room) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.running_task = out_ff.running_task;
   assign rsp_chan.switched     = out_ff.switched;
   assign rsp_chan.done_a       = out_ff.done_a;
   assign rsp_chan.done_b       = out_ff.done_b;
   assign rsp_chan.missed_a     = out_ff.missed_a;
   assign rsp_chan.missed_b     = out_ff.missed_b;
   assign rsp_chan.misses_a     = out_ff.misses_a;
   assign rsp_chan.misses_b     = out_ff.misses_b;
   assign rsp_chan.now_tick     = out_ff.now_tick;

endmodule

// File: rtl/core/edf2_checker.sv
// ----------------------------------------------------------------------------
// edf2_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "edf_two_task_scheduler_defines.svh"

module edf2_checker import edf2_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              done_a,
   input logic              done_b,
   input logic              missed_a,
   input logic              missed_b,
   input logic [MISS_W-1:0] misses_a,
   input logic [MISS_W-1:0] misses_b
);

   // a stalled response transaction stays offered
   `EDF2_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   `EDF2_ASSERT_NXT_ALL(a_reset_empty, reset, !rsp_valid)

   // a finishing task goes inactive, so it cannot also miss on that tick
   `EDF2_ASSERT_IMP(a_done_no_miss, rsp_valid, !(done_a && missed_a) && !(done_b && missed_b))

   `EDF2_ASSERT_IMP(a_miss_counted, rsp_valid && (missed_a || missed_b),
                    (!missed_a || misses_a != '0) && (!missed_b || misses_b != '0))

endmodule

bind edf_two_task_scheduler edf2_checker u_edf2_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .done_a    (rsp_chan.done_a),
   .done_b    (rsp_chan.done_b),
   .missed_a  (rsp_chan.missed_a),
   .missed_b  (rsp_chan.missed_b),
   .misses_a  (rsp_chan.misses_a),
   .misses_b  (rsp_chan.misses_b)
);
